@@ rtl/core/swing_step_sequencer_assert.svh @@
// Assertion macros for the sequencer RTL.
// No dependencies; included by the datapath, which checks its own logic.
`ifndef SWING_STEP_SEQUENCER_ASSERT_SVH
`define SWING_STEP_SEQUENCER_ASSERT_SVH

// invariant that holds on every edge out of reset
`define SSS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("invariant violated");

// same-cycle implication
`define SSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication violated");

// next-cycle implication
`define SSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

@@ rtl/core/sss_pkg.sv @@
// Package for the swing step sequencer: op, event and mode codes, constants,
// and the controller/datapath command and status structs. No dependencies.
package sss_pkg;

	localparam int STEPS_DEF     = 64;
	localparam int TEMPO_MIN_DEF = 30;
	localparam int TEMPO_MAX_DEF = 300;

	localparam logic [3:0] OP_TICK      = 4'd0;
	localparam logic [3:0] OP_PLAY      = 4'd1;
	localparam logic [3:0] OP_STOP      = 4'd2;
	localparam logic [3:0] OP_REC_START = 4'd3;
	localparam logic [3:0] OP_REC_STOP  = 4'd4;
	localparam logic [3:0] OP_SET_STEP  = 4'd5;
	localparam logic [3:0] OP_CLR_STEP  = 4'd6;
	localparam logic [3:0] OP_CLR_ALL   = 4'd7;
	localparam logic [3:0] OP_LIVE_NOTE = 4'd8;

	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_NOTE_ON = 2'd1;
	localparam logic [1:0] EV_ALL_OFF = 2'd2;

	localparam logic [1:0] MODE_LIVE = 2'd0;
	localparam logic [1:0] MODE_PLAY = 2'd1;
	localparam logic [1:0] MODE_EDIT = 2'd2;

	localparam logic [7:0] NOTE_EMPTY    = 8'hFF;
	localparam logic [7:0] GATE_DEFAULT  = 8'd100;
	localparam logic [7:0] GATE_RECORDED = 8'd80;
	localparam logic [7:0] SWING_MAX     = 8'd100;

	localparam int TEMPO_RESET = 120;

	// divider sizing: 19-bit base times 14-bit scale fits 34 bits
	localparam int DIV_W = 34;
	localparam int DVS_W = 14;
	localparam int CNT_W = 6;
	localparam logic [DIV_W-1:0] BASE_DIVIDEND = 34'd15000000;
	localparam logic [DVS_W-1:0] SCALE_DIV     = 14'd10000;

	// x/10000 = (x>>4)/625; ceil(2^39/625) is exact for x>>4 below 2^29
	localparam int          RCP_W     = 59;
	localparam int          RCP_SHIFT = 39;
	localparam logic [29:0] RCP_625   = 30'd879609303;

	typedef struct packed {
		logic       accent;
		logic [7:0] gate;
		logic [7:0] velocity;
		logic [7:0] note;
	} step_t;

	typedef struct packed {
		logic load;
		logic start_div1;
		logic take_base;
		logic mul;
		logic rcp_mul;
		logic take_int;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic tick_play;
		logic swing_zero;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

@@ rtl/core/sss_div.sv @@
// Restoring divider, one quotient bit per cycle, for the tempo division.
// Depends on sss_pkg.
module sss_div
	import sss_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	logic [DIV_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   rem_sh;
	logic [DVS_W:0]   rem_sub;
	logic             ge;

	always_comb begin
		rem_sh  = {rem_q, dvd_q[DIV_W-1]};
		ge      = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
			rem_q <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

@@ rtl/core/sss_datapath.sv @@
// Datapath: pattern store with valid bits, transport state, interval arithmetic
// and the result register. Depends on sss_pkg, sss_div and the assertion header.
module sss_datapath
	import sss_pkg::*;
#(
	parameter int STEPS     = STEPS_DEF,
	parameter int TEMPO_MIN = TEMPO_MIN_DEF,
	parameter int TEMPO_MAX = TEMPO_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output status_t     status,
	input  logic [9:0]  tempo_bpm,
	input  logic [7:0]  swing_amount,
	input  logic [3:0]  op,
	input  logic [5:0]  step_index,
	input  logic [7:0]  note,
	input  logic [7:0]  velocity,
	input  logic [7:0]  gate,
	input  logic        accent,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [1:0]  event_res,
	output logic [7:0]  out_note,
	output logic [7:0]  out_velocity,
	output logic [7:0]  out_gate,
	output logic        out_accent,
	output logic [5:0]  played_step,
	output logic [19:0] interval_us,
	output logic        is_playing,
	output logic        is_recording,
	output logic [1:0]  mode_now,
	output logic        step_advanced
);

	localparam int IW = $clog2(STEPS);

	step_t mem [STEPS];
	step_t rd_q;

	logic [3:0]  op_q;
	logic [5:0]  idx_q;
	logic [7:0]  note_q, vel_q, gate_q;
	logic        acc_q;

	logic [IW-1:0]    pos_q;
	logic             playing_q, recording_q;
	logic [1:0]       mode_q;
	logic [7:0]       held_note_q, held_vel_q;
	logic [STEPS-1:0] nv_valid_q, ga_valid_q;

	logic [19:0]      base_q, int_q;
	logic [DIV_W-1:0] prod_q;
	logic [RCP_W-1:0] rcp_q;

	logic             m_tvalid_q;

	// combinational
	logic             tick_play, idx_ok, capture;
	logic [IW-1:0]    idx_a, pos_nx;
	step_t            ent;
	logic [6:0]       swing_s;
	logic [11:0]      s33;
	logic [13:0]      num;
	logic [9:0]       tsat;
	logic             div_start, div_busy, div_done;
	logic [DIV_W-1:0] div_dvd, div_q;
	logic [DVS_W-1:0] div_dvs;
	logic             we;
	logic [IW-1:0]    wa;
	step_t            wd;
	logic             play_d, rec_d;
	logic [1:0]       mode_d, ev_d;

	always_comb begin
		tick_play = (op_q == OP_TICK) && playing_q;
		idx_ok    = int'(idx_q) < STEPS;
		idx_a     = IW'(idx_q);
		pos_nx    = (pos_q == IW'(STEPS - 1)) ? '0 : pos_q + 1'b1;
		capture   = tick_play && recording_q && (held_note_q != NOTE_EMPTY);

		// fields not written since their last clear read as those of the empty step
		ent.note     = nv_valid_q[pos_q] ? rd_q.note : NOTE_EMPTY;
		ent.velocity = nv_valid_q[pos_q] ? rd_q.velocity : 8'd0;
		ent.gate     = ga_valid_q[pos_q] ? rd_q.gate : GATE_DEFAULT;
		ent.accent   = ga_valid_q[pos_q] ? rd_q.accent : 1'b0;

		swing_s = (swing_amount > SWING_MAX) ? SWING_MAX[6:0] : swing_amount[6:0];
		s33     = {swing_s, 5'b0} + 12'(swing_s);
		num     = pos_q[0] ? SCALE_DIV + 14'(s33) : SCALE_DIV - 14'(s33);

		if (int'(tempo_bpm) < TEMPO_MIN)
			tsat = 10'(TEMPO_MIN);
		else if (int'(tempo_bpm) > TEMPO_MAX)
			tsat = 10'(TEMPO_MAX);
		else
			tsat = tempo_bpm;

		div_start = cmd.start_div1;
		div_dvd   = BASE_DIVIDEND;
		div_dvs   = DVS_W'(tsat);

		we = 1'b0;
		wa = idx_a;
		wd = '{accent: acc_q, gate: gate_q, velocity: vel_q, note: note_q};
		if (cmd.commit) begin
			if (capture) begin
				we = 1'b1;
				wa = pos_q;
				wd = '{accent: 1'b0, gate: GATE_RECORDED, velocity: held_vel_q,
					note: held_note_q};
			end else if (op_q == OP_SET_STEP && idx_ok) begin
				we = 1'b1;
			end
		end

		play_d = playing_q;
		rec_d  = recording_q;
		mode_d = mode_q;
		ev_d   = EV_NONE;
		case (op_q)
			OP_TICK: begin
				if (tick_play)
					ev_d = (ent.note != NOTE_EMPTY && ent.velocity != 8'd0) ?
						EV_NOTE_ON : EV_ALL_OFF;
			end
			OP_PLAY: begin
				play_d = 1'b1;
				mode_d = MODE_PLAY;
			end
			OP_STOP: begin
				play_d = 1'b0;
				rec_d  = 1'b0;
				ev_d   = EV_ALL_OFF;
			end
			OP_REC_START: begin
				play_d = 1'b1;
				rec_d  = 1'b1;
				mode_d = MODE_LIVE;
			end
			OP_REC_STOP: begin
				rec_d = 1'b0;
				if (mode_q == MODE_LIVE)
					mode_d = MODE_EDIT;
			end
			default: ;
		endcase

		status.tick_play  = tick_play;
		status.swing_zero = (swing_s == 7'd0);
		status.div_done   = div_done;
		status.out_free   = !m_tvalid_q || m_tready;
	end

	sss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (cmd.load)
			rd_q <= mem[pos_q];
	end

	// captured item and arithmetic payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			idx_q  <= step_index;
			note_q <= note;
			vel_q  <= velocity;
			gate_q <= gate;
			acc_q  <= accent;
		end
		if (cmd.take_base) begin
			base_q <= div_q[19:0];
			int_q  <= div_q[19:0];
		end
		if (cmd.mul)
			prod_q <= DIV_W'(base_q) * DIV_W'(num);
		// scaled product stays below 2^33, so bits 32:4 carry all of prod_q>>4
		if (cmd.rcp_mul)
			rcp_q <= RCP_W'(prod_q[32:4]) * RCP_W'(RCP_625);
		if (cmd.take_int)
			int_q <= rcp_q[RCP_SHIFT+19:RCP_SHIFT];
		if (cmd.commit) begin
			event_res     <= ev_d;
			out_note      <= tick_play ? ent.note : 8'd0;
			out_velocity  <= tick_play ? ent.velocity : 8'd0;
			out_gate      <= tick_play ? ent.gate : 8'd0;
			out_accent    <= tick_play ? ent.accent : 1'b0;
			played_step   <= tick_play ? 6'(pos_q) : 6'd0;
			interval_us   <= tick_play ? int_q : 20'd0;
			is_playing    <= play_d;
			is_recording  <= rec_d;
			mode_now      <= mode_d;
			step_advanced <= tick_play;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			playing_q   <= 1'b0;
			recording_q <= 1'b0;
			mode_q      <= MODE_LIVE;
			held_note_q <= NOTE_EMPTY;
			held_vel_q  <= 8'd0;
			nv_valid_q  <= '0;
			ga_valid_q  <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cmd.commit)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			if (cmd.commit) begin
				playing_q   <= play_d;
				recording_q <= rec_d;
				mode_q      <= mode_d;
				if (we) begin
					nv_valid_q[wa] <= 1'b1;
					ga_valid_q[wa] <= 1'b1;
				end
				case (op_q)
					OP_TICK: begin
						if (tick_play)
							pos_q <= pos_nx;
						if (capture)
							held_note_q <= NOTE_EMPTY;
					end
					OP_PLAY: pos_q <= '0;
					OP_REC_START: begin
						pos_q      <= '0;
						nv_valid_q <= '0;
					end
					OP_CLR_STEP: begin
						if (idx_ok) begin
							nv_valid_q[idx_a] <= 1'b0;
							ga_valid_q[idx_a] <= 1'b0;
						end
					end
					OP_CLR_ALL: begin
						nv_valid_q <= '0;
						ga_valid_q <= '0;
					end
					OP_LIVE_NOTE: begin
						held_note_q <= note_q;
						held_vel_q  <= vel_q;
					end
					default: ;
				endcase
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

`include "swing_step_sequencer_assert.svh"

	`SSS_ASSERT_ALWAYS(a_rec_implies_play, clk, arst_n, !recording_q || playing_q)
	`SSS_ASSERT_IMP(a_commit_slot_free, clk, arst_n, cmd.commit, !m_tvalid_q || m_tready)
	`SSS_ASSERT_NXT(a_commit_shows, clk, arst_n, cmd.commit, m_tvalid_q)
	`SSS_ASSERT_IMP(a_div_done_after_busy, clk, arst_n, div_done, $past(div_busy))

endmodule

@@ rtl/core/sss_ctrl.sv @@
// Controller state machine: sequences capture, divide, multiply and commit.
// Depends on sss_pkg.
module sss_ctrl
	import sss_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_DIV1 = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_RCP  = 3'd4;
	localparam logic [2:0] ST_SCL  = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [2:0] state_q, state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		s_tready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (status.tick_play) begin
					cmd.start_div1 = 1'b1;
					state_d        = ST_DIV1;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_DIV1: begin
				if (status.div_done) begin
					cmd.take_base = 1'b1;
					state_d       = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = status.swing_zero ? ST_FIN : ST_RCP;
			end
			ST_RCP: begin
				cmd.rcp_mul = 1'b1;
				state_d     = ST_SCL;
			end
			ST_SCL: begin
				cmd.take_int = 1'b1;
				state_d      = ST_FIN;
			end
			ST_FIN: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

@@ rtl/core/swing_step_sequencer.sv @@
// Top level of the swing step sequencer: APB registers, controller, datapath.
// Depends on sss_pkg, sss_ctrl and sss_datapath.
//
// channel  | direction | handshake          | payload
// s_*      | in        | s_tvalid/s_tready  | s_tuser op, s_tdata step fields
// m_*      | out       | m_tvalid/m_tready  | m_tuser event, m_tdata result
// apb      | in        | psel/penable/pready| tempo_bpm @0x0, swing_amount @0x4
//
// A tick while playing passes from accept through the restoring tempo divider,
// then the swing multiply and a reciprocal multiply for the /10000; with zero
// swing the reciprocal multiply is skipped. Every other op goes from accept
// to commit without the arithmetic. Reset clears the store at once through
// per-step valid bits; no sweep. One item is in work at a time; the next is
// taken while a result waits in the output register, and the commit holds
// until that register frees.
module swing_step_sequencer
	import sss_pkg::*;
#(
	parameter int STEPS     = STEPS_DEF,
	parameter int TEMPO_MIN = TEMPO_MIN_DEF,
	parameter int TEMPO_MAX = TEMPO_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [5:0] step_index, [13:6] note, [21:14] velocity, [29:22] gate, [30] accent
	input  logic [31:0] s_tdata,
	// [3:0] op
	input  logic [3:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] out_note, [15:8] out_velocity, [23:16] out_gate, [24] out_accent,
	// [30:25] played_step, [50:31] interval_us, [51] is_playing,
	// [52] is_recording, [54:53] mode_now, [55] step_advanced
	output logic [55:0] m_tdata,
	// [1:0] event_res
	output logic [1:0]  m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic REG_TEMPO = 1'b0;

	logic [9:0] tempo_q;
	logic [7:0] swing_q;
	cmd_t       cmd;
	status_t    status;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TEMPO) ? 32'(tempo_q) : 32'(swing_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_q <= 10'(TEMPO_RESET);
			swing_q <= 8'd0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_TEMPO)
				tempo_q <= pwdata[9:0];
			else
				swing_q <= pwdata[7:0];
		end
	end

	sss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sss_datapath #(
		.STEPS     (STEPS),
		.TEMPO_MIN (TEMPO_MIN),
		.TEMPO_MAX (TEMPO_MAX)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.tempo_bpm     (tempo_q),
		.swing_amount  (swing_q),
		.op            (s_tuser),
		.step_index    (s_tdata[5:0]),
		.note          (s_tdata[13:6]),
		.velocity      (s_tdata[21:14]),
		.gate          (s_tdata[29:22]),
		.accent        (s_tdata[30]),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.event_res     (m_tuser),
		.out_note      (m_tdata[7:0]),
		.out_velocity  (m_tdata[15:8]),
		.out_gate      (m_tdata[23:16]),
		.out_accent    (m_tdata[24]),
		.played_step   (m_tdata[30:25]),
		.interval_us   (m_tdata[50:31]),
		.is_playing    (m_tdata[51]),
		.is_recording  (m_tdata[52]),
		.mode_now      (m_tdata[54:53]),
		.step_advanced (m_tdata[55])
	);

endmodule

@@ sim/tb_top.sv @@
// Testbench for swing_step_sequencer: directed table then random ops, checked
// against an in-bench sequencer predictor. Depends on sss_pkg and the RTL.
module tb_top;
	import sss_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]  ev;
		logic [7:0]  note;
		logic [7:0]  vel;
		logic [7:0]  gate;
		logic        acc;
		logic [5:0]  step;
		logic [19:0] intv;
		logic        playing;
		logic        recording;
		logic [1:0]  mode;
		logic        adv;
	} seq_res_t;

	typedef struct packed {
		logic [3:0] op;
		logic [5:0] idx;
		logic [7:0] note;
		logic [7:0] vel;
		logic [7:0] gate;
		logic       acc;
	} seq_cmd_t;

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0, pready;
	logic [31:0] s_tdata = 0, pwdata = 0, prdata;
	logic [3:0] s_tuser = 0;
	logic [55:0] m_tdata;
	logic [1:0] m_tuser;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = 0;

	swing_step_sequencer dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// predictor state
	step_t pat [64];
	logic [5:0] pos;
	logic playing, recording;
	logic [1:0] mode;
	logic [7:0] held_note, held_vel;
	int unsigned tempo = TEMPO_RESET, swing = 0;

	seq_res_t expected_q [$];
	int errors = 0, results_seen = 0, ticks_played = 0;
	int send_idle = 0, recv_idle = 0;
	longint cycles = 0;

	function automatic logic [19:0] swung_us(logic [5:0] p);
		longint unsigned t, b, s;
		t = tempo < TEMPO_MIN_DEF ? TEMPO_MIN_DEF : tempo;
		if (t > TEMPO_MAX_DEF) t = TEMPO_MAX_DEF;
		b = 15000000 / t;
		s = swing > 100 ? 100 : swing;
		if (s > 0) b = b * (p[0] ? 10000 + 33 * s : 10000 - 33 * s) / 10000;
		return b[19:0];
	endfunction

	function automatic seq_res_t sequence_step(seq_cmd_t c);
		seq_res_t r;
		r = '0;
		case (c.op)
			OP_TICK: if (playing) begin
				r.intv = swung_us(pos);
				{r.acc, r.gate, r.vel, r.note} = pat[pos];
				r.step = pos;
				r.ev = (pat[pos].note != NOTE_EMPTY && pat[pos].velocity != 0) ?
					EV_NOTE_ON : EV_ALL_OFF;
				if (recording && held_note != NOTE_EMPTY) begin
					pat[pos] = {1'b0, GATE_RECORDED, held_vel, held_note};
					held_note = NOTE_EMPTY;
				end
				pos = pos + 1;
				r.adv = 1;
			end
			OP_PLAY: begin
				playing = 1; pos = 0; mode = MODE_PLAY;
			end
			OP_STOP: begin
				playing = 0; recording = 0; r.ev = EV_ALL_OFF;
			end
			OP_REC_START: begin
				recording = 1; playing = 1; pos = 0; mode = MODE_LIVE;
				foreach (pat[i]) begin
					pat[i].note = NOTE_EMPTY;
					pat[i].velocity = 0;
				end
			end
			OP_REC_STOP: begin
				recording = 0;
				if (mode == MODE_LIVE) mode = MODE_EDIT;
			end
			OP_SET_STEP: pat[c.idx] = {c.acc, c.gate, c.vel, c.note};
			OP_CLR_STEP: pat[c.idx] = {1'b0, GATE_DEFAULT, 8'd0, NOTE_EMPTY};
			OP_CLR_ALL: foreach (pat[i]) pat[i] = {1'b0, GATE_DEFAULT, 8'd0, NOTE_EMPTY};
			OP_LIVE_NOTE: begin
				held_note = c.note; held_vel = c.vel;
			end
			default: ;
		endcase
		r.playing = playing;
		r.recording = recording;
		r.mode = mode;
		return r;
	endfunction

	// receiver side and checker
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("%0t timeout", $realtime);
			$display("tb_top failed");
			$finish;
		end
		if (m_tvalid && m_tready) begin
			seq_res_t got, want;
			got = {m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[24],
				m_tdata[30:25], m_tdata[50:31], m_tdata[51], m_tdata[52],
				m_tdata[54:53], m_tdata[55]};
			results_seen++;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t unexpected result %h", $realtime, got);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t mismatch: expected %h actual %h", $realtime, want, got);
				end
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic reg_write(logic [2:0] addr, logic [31:0] val);
		@(posedge clk);
		psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (addr == 0) tempo = val[9:0];
		else swing = val[7:0];
	endtask

	// send one item; an optional typed-in result overrides the predictor's
	task automatic send(seq_cmd_t c, bit has_fixed = 0, seq_res_t fixed = '0);
		seq_res_t r;
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= c.op;
		s_tdata <= {1'b0, c.acc, c.gate, c.vel, c.note, c.idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = sequence_step(c);
		if (r.adv) ticks_played++;
		if (has_fixed && r !== fixed) begin
			errors++;
			$display("%0t table row: expected %h predicted %h", $realtime, fixed, r);
		end
		expected_q.push_back(has_fixed ? fixed : r);
	endtask

	task automatic drain;
		s_tvalid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic seq_cmd_t rand_cmd();
		seq_cmd_t c;
		int k;
		c = seq_cmd_t'(35'({$urandom, $urandom}));
		k = $urandom_range(99);
		if (k < 45) c.op = OP_TICK;
		else if (k < 60) c.op = OP_SET_STEP;
		else if (k < 72) c.op = OP_LIVE_NOTE;
		else if (k < 96) c.op = 4'($urandom_range(OP_CLR_ALL, OP_PLAY));
		else c.op = 4'($urandom_range(15, 9));
		if (c.op == OP_LIVE_NOTE && $urandom_range(3) == 0) c.note = NOTE_EMPTY;
		if (c.op == OP_SET_STEP && $urandom_range(4) == 0) c.vel = 0;
		if (c.op == OP_CLR_ALL && $urandom_range(3) != 0) c.op = OP_TICK;
		return c;
	endfunction

	typedef struct {
		seq_cmd_t c;
		bit fixed;
		seq_res_t r;
	} row_t;

	initial begin
		row_t rows [$];
		int tempos [6] = '{120, 0, 29, 300, 1023, 77};
		int swings [6] = '{0, 255, 100, 1, 50, 33};
		foreach (pat[i]) pat[i] = {1'b0, GATE_DEFAULT, 8'd0, NOTE_EMPTY};
		pos = 0; playing = 0; recording = 0; mode = MODE_LIVE;
		held_note = NOTE_EMPTY; held_vel = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// tick while stopped, tick of empty step after reset, extremes, bad ops
		rows = '{
			'{'{OP_TICK, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 1, '0},
			'{'{OP_STOP, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 1,
				'{EV_ALL_OFF, 0, 0, 0, 0, 0, 0, 0, 0, MODE_LIVE, 0}},
			'{'{OP_PLAY, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 1,
				'{EV_NONE, 0, 0, 0, 0, 0, 0, 1, 0, MODE_PLAY, 0}},
			'{'{OP_TICK, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 1,
				'{EV_ALL_OFF, 8'hFF, 0, 8'd100, 0, 0, 20'd125000, 1, 0, MODE_PLAY, 1}},
			'{'{OP_SET_STEP, 6'd1, 8'd0, 8'd255, 8'd255, 1'b1}, 0, '0},
			'{'{OP_SET_STEP, 6'd63, 8'd254, 8'd1, 8'd0, 1'b0}, 0, '0},
			'{'{OP_SET_STEP, 6'd2, 8'hFF, 8'd9, 8'd0, 1'b1}, 0, '0},
			'{'{OP_TICK, 6'd63, 8'hFF, 8'hFF, 8'hFF, 1'b1}, 0, '0},
			'{'{OP_TICK, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 0, '0},
			'{'{OP_CLR_STEP, 6'd1, 8'd0, 8'd0, 8'd0, 1'b0}, 0, '0},
			'{'{OP_LIVE_NOTE, 6'd0, 8'd60, 8'd90, 8'd0, 1'b0}, 0, '0},
			'{'{OP_REC_START, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 0, '0},
			'{'{OP_TICK, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 0, '0},
			'{'{OP_LIVE_NOTE, 6'd0, 8'hFF, 8'd5, 8'd0, 1'b0}, 0, '0},
			'{'{OP_TICK, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 0, '0},
			'{'{OP_REC_STOP, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 0, '0},
			'{'{OP_PLAY, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 0, '0},
			'{'{OP_TICK, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 0, '0},
			'{'{OP_CLR_ALL, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 0, '0},
			'{'{4'd9, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 0, '0},
			'{'{4'd15, 6'd63, 8'hFF, 8'hFF, 8'hFF, 1'b1}, 0, '0},
			'{'{OP_TICK, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 0, '0}
		};
		foreach (rows[i]) send(rows[i].c, rows[i].fixed, rows[i].r);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			reg_write(3'd0, tempos[ph]);
			reg_write(3'd4, swings[ph]);
			send_idle = ph < 2 ? 34 : ph < 4 ? 76 : 0;
			recv_idle = ph < 2 ? 76 : ph < 4 ? 34 : 0;
			// start each phase with a well-formed play or record run
			send('{$urandom_range(1) ? OP_PLAY : OP_REC_START, 0, 0, 0, 0, 0});
			for (int n = 0; n < 285; n++) send(rand_cmd());
			drain();
		end

		$display("ran %0d results, %0d played ticks over 6 tempo/swing settings",
			results_seen, ticks_played);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/sss_pkg.sv
rtl/core/sss_div.sv
rtl/core/sss_datapath.sv
rtl/core/sss_ctrl.sv
rtl/core/swing_step_sequencer.sv
sim/tb_top.sv
